// ===== sv/glcd_psw_pkg.sv =====
// Shared constants and types for the graphic LCD pixel shadow writer.
package glcd_psw_pkg;

	// Screen geometry
	localparam int SCREEN_COLUMNS = 128;
	localparam int SCREEN_ROWS    = 64;
	localparam int HALF_WIDTH     = 64;
	localparam int PAGE_COUNT     = (SCREEN_ROWS + 7) / 8;
	localparam int FRAME_DEPTH    = SCREEN_COLUMNS * PAGE_COUNT;
	localparam int ADDR_W         = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

	// Stream widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;
	localparam int OUT_USER_W = 2;

	// Controller command codes
	localparam logic [7:0] PAGE_CMD   = 8'hB8;
	localparam logic [7:0] COLUMN_CMD = 8'h40;
	localparam logic [7:0] BIT_ONE    = 8'h01;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PAGE,
		ST_COL,
		ST_DATA
	} state_t;

endpackage

// ===== sv/glcd_pixel_shadow_writer_core.sv =====
// Pixel writer for a two-controller graphic LCD with a shadow frame memory.
//
// Each accepted pixel item (column, row, on/off) updates one byte of a shadow
// frame held in a single-port synchronous memory (one byte per column and
// 8-row page) and produces three controller writes: set-page command,
// set-column command, then the updated byte as display data, tlast on the
// third. The memory is read on the accept edge, written back as the page
// command is issued, and the next item is taken on the edge that issues the
// data write. Off-screen pixels are taken and dropped, giving no writes.
// After reset the block clears the shadow memory one byte a cycle, all
// FRAME_DEPTH bytes (1024 with a 128x64 screen), and holds s_tready low
// until that is done.
module glcd_pixel_shadow_writer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// s_tdata: column [7:0], row [15:8], pixel_on [16], zero fill above
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [glcd_psw_pkg::IN_DATA_W-1:0]    s_tdata,
	// m_tdata: bus_byte [7:0]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [glcd_psw_pkg::OUT_DATA_W-1:0]   m_tdata,
	// m_tuser: is_data [0], right_half [1]
	output logic [glcd_psw_pkg::OUT_USER_W-1:0]   m_tuser,
	output logic                                  m_tlast
);
	import glcd_psw_pkg::*;

	localparam logic [8:0]        COL_LIMIT = 9'(SCREEN_COLUMNS);
	localparam logic [8:0]        ROW_LIMIT = 9'(SCREEN_ROWS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_DEPTH - 1);

	// Shadow frame memory
	logic [7:0] frame_mem [FRAME_DEPTH];

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_cnt_q;

	// Item registers
	logic [5:0]        col_q;
	logic [2:0]        page_q;
	logic [2:0]        bit_q;
	logic              on_q;
	logic              right_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        rd_data_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_is_data_q;
	logic       out_right_q;
	logic       out_last_q;

	// Input field decode
	logic [7:0]        in_col;
	logic [7:0]        in_row;
	logic              in_on;
	logic              on_screen;
	logic              in_acc;
	logic [ADDR_W-1:0] rd_addr;

	assign in_col    = s_tdata[7:0];
	assign in_row    = s_tdata[15:8];
	assign in_on     = s_tdata[16];
	assign on_screen = ({1'b0, in_col} < COL_LIMIT) && ({1'b0, in_row} < ROW_LIMIT);
	assign in_acc    = s_tvalid && s_tready;
	assign rd_addr   = ADDR_W'(int'(in_col) * PAGE_COUNT + int'(in_row[5:3]));

	// Read-modify of the fetched byte
	logic [7:0] bit_mask;
	logic [7:0] new_byte;

	assign bit_mask = BIT_ONE << bit_q;
	assign new_byte = on_q ? (rd_data_q | bit_mask) : (rd_data_q & ~bit_mask);

	// Sequencer controls
	logic              load_ok;
	logic              load;
	logic [7:0]        ld_byte;
	logic              ld_is_data;
	logic              ld_last;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;

	assign load_ok = !out_valid_q || m_tready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and controls
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		load       = 1'b0;
		ld_byte    = new_byte;
		ld_is_data = 1'b0;
		ld_last    = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = addr_q;
		wr_data    = new_byte;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
				if (clr_cnt_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && on_screen) begin
					state_d = ST_PAGE;
				end
			end
			ST_PAGE: begin
				if (load_ok) begin
					load    = 1'b1;
					ld_byte = PAGE_CMD | {5'b0, page_q};
					wr_en   = 1'b1;
					state_d = ST_COL;
				end
			end
			ST_COL: begin
				if (load_ok) begin
					load    = 1'b1;
					ld_byte = COLUMN_CMD | {2'b0, col_q};
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				if (load_ok) begin
					load       = 1'b1;
					ld_byte    = new_byte;
					ld_is_data = 1'b1;
					ld_last    = 1'b1;
					s_tready   = 1'b1;
					state_d    = (s_tvalid && on_screen) ? ST_PAGE : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	// Shadow memory: one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= wr_data;
		end
		if (in_acc && on_screen) begin
			rd_data_q <= frame_mem[rd_addr];
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q   <= in_col[5:0];
			page_q  <= in_row[5:3];
			bit_q   <= in_row[2:0];
			on_q    <= in_on;
			right_q <= in_col[7] | in_col[6];
			addr_q  <= rd_addr;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q    <= ld_byte;
			out_is_data_q <= ld_is_data;
			out_right_q   <= right_q;
			out_last_q    <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_right_q, out_is_data_q};
	assign m_tlast  = out_last_q;

	// No item is taken while the memory is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_tready)
		else $error("item accepted during clearing pass");

	// The last write of a run is always the data write
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("tlast on a command write");

	// An on-screen item starts its run with the page command
	a_accept_to_page: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && on_screen |=> state_q == ST_PAGE)
		else $error("on-screen item did not start a run");

	// Write-back is followed by the column command
	a_writeback_to_col: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAGE && wr_en |=> state_q == ST_COL && m_tvalid)
		else $error("write-back not followed by the column step");

endmodule
